// ===== rtl/core/nfc_rfp_pkg.sv =====
// shared types and constants for the response frame parser
// no dependencies; compiled first

package nfc_rfp_pkg;

    localparam int unsigned BYTE_W = 8;

    // frame constants
    localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] START_BYTE    = 8'hFF;
    localparam logic [BYTE_W-1:0] DIR_TO_HOST   = 8'hD5;
    localparam logic [BYTE_W-1:0] TRAILER_BYTES = 8'd2;
    localparam logic [BYTE_W-1:0] HEADER_BYTES  = 8'd2;

    // configuration register indexes
    localparam logic CFG_EXPECTED_COMMAND = 1'b0;
    localparam logic CFG_BUFFER_CAPACITY  = 1'b1;

    // final status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic              is_payload;
        logic              done_res;
        logic [1:0]        status;
        logic [BYTE_W-1:0] payload_length;
    } out_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_command;
        logic [BYTE_W-1:0] buffer_capacity;
    } cfg_t;

    // result handed from the parser to the output stage
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } step_t;

endpackage

// ===== rtl/core/nfc_rfp_ifs.sv =====
// valid/ready channel interfaces for frame bytes and parser results
// depends on nfc_rfp_pkg

interface nfc_rfp_in_if import nfc_rfp_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nfc_rfp_out_if import nfc_rfp_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/nfc_response_frame_parser_core.sv =====
// top level of the response frame parser: config registers, parser, result register
// depends on nfc_rfp_pkg, nfc_rfp_ifs, nfc_rfp_cfg, nfc_rfp_parser, nfc_rfp_out_stage

// Parses one host-interface response frame per run of bytes on the frame channel
// (preamble marked by frame_start, then 00 FF, length, length checksum, direction
// byte D5, response code, payload, data checksum, postamble). Each payload byte
// comes out as one result request with its index; the frame ends with one result
// carrying done_res, the status (ok, invalid frame, no space) and the payload
// length. A frame is rejected at the first bad start, length, direction, code or
// checksum byte and the rest is ignored until the next frame_start. Payloads
// longer than buffer_capacity are dropped with the two trailer bytes and reported
// as no space. One byte is taken every cycle unless the result channel stalls;
// each byte is held in the input register and then moves to the result register,
// from which its result is offered. The parse state is updated from the input
// register. Ready on the frame channel follows ready on the result channel in the
// same cycle when both registers are full. Write the configuration registers only
// while no frame is in flight.

module nfc_response_frame_parser_core import nfc_rfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_wdata,
    // frame bytes in, results out
    nfc_rfp_in_if.sink        frame,
    nfc_rfp_out_if.source     res
);

    cfg_t  cfg;
    step_t step;
    logic  space;

    // expected command and buffer capacity, sampled at the response code byte
    nfc_rfp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register and frame state machine
    nfc_rfp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .frame (frame),
        .cfg   (cfg),
        .space (space),
        .step  (step)
    );

    // result register; space lets the parser retire a byte
    nfc_rfp_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .space (space),
        .res   (res)
    );

endmodule

// ===== rtl/core/nfc_rfp_cfg.sv =====
// configuration registers: expected command and buffer capacity
// depends on nfc_rfp_pkg

module nfc_rfp_cfg import nfc_rfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPECTED_COMMAND: cfg_next.expected_command = cfg_wdata;
                CFG_BUFFER_CAPACITY:  cfg_next.buffer_capacity  = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_command <= '0;
            cfg_reg.buffer_capacity  <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/nfc_rfp_parser.sv =====
// input register and parser FSM, one byte per cycle unless stalled
// depends on nfc_rfp_pkg and nfc_rfp_in_if

module nfc_rfp_parser import nfc_rfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    nfc_rfp_in_if.sink  frame,
    input  cfg_t        cfg,
    input  logic        space,
    output step_t       step
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SC1,
        PH_SC2,
        PH_LEN,
        PH_LCS,
        PH_TFI,
        PH_CMD,
        PH_DATA,
        PH_DCS,
        PH_POST,
        PH_TRAIL
    } phase_t;

    logic              in_valid_reg, in_valid_next;
    in_item_t          in_item_reg, in_item_next;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] remaining_reg, remaining_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] index_reg, index_next;
    logic              overflow_reg, overflow_next;

    logic              accept;
    logic              fire;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] plen;
    logic [BYTE_W-1:0] rem_dec;
    logic [BYTE_W-1:0] expected_code;
    out_item_t         res;
    logic              res_valid;

    assign frame.ready = !in_valid_reg || space;
    assign accept      = frame.valid && frame.ready;
    assign fire        = in_valid_reg && space;

    assign b             = in_item_reg.rx_byte;
    assign plen          = length_reg - HEADER_BYTES;
    assign rem_dec       = remaining_reg - 8'd1;
    assign expected_code = cfg.expected_command + 8'd1;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        length_next    = length_reg;
        index_next     = index_reg;
        overflow_next  = overflow_reg;
        res            = '0;
        res_valid      = 1'b0;

        if (fire)
        begin
            in_valid_next = 1'b0;
        end
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_item_next  = frame.data;
        end

        if (fire)
        begin
            if (in_item_reg.frame_start)
            begin
                // restart drops any frame in progress
                remaining_next = '0;
                sum_next       = '0;
                length_next    = '0;
                index_next     = '0;
                overflow_next  = 1'b0;
                if (b != PREAMBLE_BYTE)
                begin
                    res_valid    = 1'b1;
                    res.done_res = 1'b1;
                    res.status   = ST_INVALID;
                    phase_next   = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_SC1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SC1:
                    begin
                        if (b != PREAMBLE_BYTE)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_SC2;
                        end
                    end
                    PH_SC2:
                    begin
                        if (b != START_BYTE)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        length_next = b;
                        phase_next  = PH_LCS;
                    end
                    PH_LCS:
                    begin
                        if ((length_reg + b) != 8'd0 || length_reg < HEADER_BYTES)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_TFI;
                        end
                    end
                    PH_TFI:
                    begin
                        if (b != DIR_TO_HOST)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        if (b != expected_code)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            sum_next       = DIR_TO_HOST + b;
                            index_next     = '0;
                            remaining_next = plen;
                            overflow_next  = (plen > cfg.buffer_capacity);
                            phase_next     = (plen == 8'd0) ? PH_DCS : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (!overflow_reg)
                        begin
                            res_valid         = 1'b1;
                            res.payload_byte  = b;
                            res.payload_index = index_reg;
                            res.is_payload    = 1'b1;
                            sum_next          = sum_reg + b;
                        end
                        index_next     = index_reg + 8'd1;
                        remaining_next = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            if (overflow_reg)
                            begin
                                phase_next     = PH_TRAIL;
                                remaining_next = TRAILER_BYTES;
                            end
                            else
                            begin
                                phase_next = PH_DCS;
                            end
                        end
                    end
                    PH_TRAIL:
                    begin
                        remaining_next = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            res_valid          = 1'b1;
                            res.done_res       = 1'b1;
                            res.status         = ST_NO_SPACE;
                            res.payload_length = plen;
                            phase_next         = PH_IDLE;
                        end
                    end
                    PH_DCS:
                    begin
                        if ((sum_reg + b) != 8'd0)
                        begin
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                            res.status   = ST_INVALID;
                            phase_next   = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = PH_POST;
                        end
                    end
                    PH_POST:
                    begin
                        // postamble value is not checked
                        res_valid          = 1'b1;
                        res.done_res       = 1'b1;
                        res.status         = ST_OK;
                        res.payload_length = plen;
                        phase_next         = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            remaining_reg <= '0;
            sum_reg       <= '0;
            length_reg    <= '0;
            index_reg     <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            length_reg    <= length_next;
            index_reg     <= index_next;
            overflow_reg  <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    assign step.valid = res_valid;
    assign step.item  = res;

endmodule

// ===== rtl/core/nfc_rfp_out_stage.sv =====
// result register between the parser and the result channel
// depends on nfc_rfp_pkg and nfc_rfp_out_if

module nfc_rfp_out_stage import nfc_rfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  step_t         step,
    output logic          space,
    nfc_rfp_out_if.source res
);

    logic      valid_reg, valid_next;
    out_item_t item_reg, item_next;

    assign space = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (space)
        begin
            valid_next = step.valid;
            if (step.valid)
            begin
                item_next = step.item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign res.valid = valid_reg;
    assign res.data  = item_reg;

endmodule

// ===== dv/nfc_rfp_frame_checker.sv =====
`timescale 1ns / 1ps
// passive checker for the response frame parser: predicts results from accepted
// frame bytes and register writes, then compares them with the result channel
// depends on nfc_rfp_pkg and nfc_rfp_ifs

module nfc_rfp_frame_checker
    import nfc_rfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_wdata,
    nfc_rfp_in_if             frame,
    nfc_rfp_out_if            res,
    output int                mismatches,
    output int                pending,
    output int                payload_seen,
    output int                ok_frames,
    output int                invalid_frames,
    output int                no_space_frames
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_SYNC0, PH_SYNC_FF, PH_LEN, PH_LEN_CS, PH_DIR,
        PH_CODE, PH_DATA, PH_DATA_CS, PH_POST, PH_TRAIL
    } parse_phase_t;

    parse_phase_t      phase;
    logic [BYTE_W-1:0] bytes_left;
    logic [BYTE_W-1:0] data_sum;
    logic [BYTE_W-1:0] len_field;
    logic [BYTE_W-1:0] data_idx;
    logic              drop_payload;
    logic [BYTE_W-1:0] last_command;
    logic [BYTE_W-1:0] capacity;
    out_item_t         awaited_results[$];

    function automatic out_item_t close_frame(input logic [1:0] st,
                                              input logic [BYTE_W-1:0] plen);
        out_item_t r;
        r                = '0;
        r.done_res       = 1'b1;
        r.status         = st;
        r.payload_length = plen;
        phase            = PH_IDLE;
        return r;
    endfunction

    // next parser state for one byte; returns 1 when the byte yields a result
    function automatic bit parse_frame_byte(input in_item_t req, output out_item_t r);
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] plen;
        bit                hit;
        b    = req.rx_byte;
        plen = len_field - HEADER_BYTES;
        r    = '0;
        hit  = 1'b0;
        if (req.frame_start)
        begin
            bytes_left   = '0;
            data_sum     = '0;
            len_field    = '0;
            data_idx     = '0;
            drop_payload = 1'b0;
            if (b != PREAMBLE_BYTE)
            begin
                r   = close_frame(ST_INVALID, '0);
                hit = 1'b1;
            end
            else
            begin
                phase = PH_SYNC0;
            end
            return hit;
        end
        case (phase)
            PH_SYNC0:
            begin
                if (b != PREAMBLE_BYTE)
                begin
                    r   = close_frame(ST_INVALID, '0);
                    hit = 1'b1;
                end
                else phase = PH_SYNC_FF;
            end
            PH_SYNC_FF:
            begin
                if (b != START_BYTE)
                begin
                    r   = close_frame(ST_INVALID, '0);
                    hit = 1'b1;
                end
                else phase = PH_LEN;
            end
            PH_LEN:
            begin
                len_field = b;
                phase     = PH_LEN_CS;
            end
            PH_LEN_CS:
            begin
                if (((len_field + b) & 8'hFF) != 0 || len_field < HEADER_BYTES)
                begin
                    r   = close_frame(ST_INVALID, '0);
                    hit = 1'b1;
                end
                else phase = PH_DIR;
            end
            PH_DIR:
            begin
                if (b != DIR_TO_HOST)
                begin
                    r   = close_frame(ST_INVALID, '0);
                    hit = 1'b1;
                end
                else phase = PH_CODE;
            end
            PH_CODE:
            begin
                if (b != last_command + 8'd1)
                begin
                    r   = close_frame(ST_INVALID, '0);
                    hit = 1'b1;
                end
                else
                begin
                    data_sum     = DIR_TO_HOST + b;
                    data_idx     = '0;
                    bytes_left   = plen;
                    drop_payload = plen > capacity;
                    phase        = (plen == 0) ? PH_DATA_CS : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (!drop_payload)
                begin
                    r.payload_byte  = b;
                    r.payload_index = data_idx;
                    r.is_payload    = 1'b1;
                    data_sum        = data_sum + b;
                    hit             = 1'b1;
                end
                data_idx   = data_idx + 8'd1;
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 0)
                begin
                    if (drop_payload)
                    begin
                        phase      = PH_TRAIL;
                        bytes_left = TRAILER_BYTES;
                    end
                    else phase = PH_DATA_CS;
                end
            end
            PH_TRAIL:
            begin
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 0)
                begin
                    r   = close_frame(ST_NO_SPACE, plen);
                    hit = 1'b1;
                end
            end
            PH_DATA_CS:
            begin
                if (((data_sum + b) & 8'hFF) != 0)
                begin
                    r   = close_frame(ST_INVALID, '0);
                    hit = 1'b1;
                end
                else phase = PH_POST;
            end
            PH_POST:
            begin
                r   = close_frame(ST_OK, plen);
                hit = 1'b1;
            end
            default: phase = PH_IDLE;
        endcase
        return hit;
    endfunction

    function automatic string show(input out_item_t r);
        return $sformatf("byte=%02h idx=%0d payload=%b done=%b status=%0d len=%0d",
                         r.payload_byte, r.payload_index, r.is_payload, r.done_res,
                         r.status, r.payload_length);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        out_item_t next_res;
        if (!rst_n)
        begin
            phase        = PH_IDLE;
            bytes_left   = '0;
            data_sum     = '0;
            len_field    = '0;
            data_idx     = '0;
            drop_payload = 1'b0;
            last_command = 8'h00;
            capacity     = 8'hFF;
            awaited_results.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EXPECTED_COMMAND: last_command = cfg_wdata;
                    CFG_BUFFER_CAPACITY:  capacity     = cfg_wdata;
                    default: ;
                endcase
            end
            // a result leaves after its byte is taken, so compare before predicting
            if (res.valid && res.ready)
            begin
                got = res.data;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing awaited: %s", $time, show(got));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $time, show(want), show(got));
                    end
                    if (want.is_payload) payload_seen++;
                    else if (want.status == ST_OK) ok_frames++;
                    else if (want.status == ST_NO_SPACE) no_space_frames++;
                    else invalid_frames++;
                end
            end
            if (frame.valid && frame.ready)
            begin
                if (parse_frame_byte(frame.data, next_res))
                    awaited_results.push_back(next_res);
            end
            pending = awaited_results.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// top of the response frame parser testbench: clock, reset, register writes,
// frame byte stimulus, result back-pressure and the verdict
// depends on nfc_rfp_pkg, nfc_rfp_ifs, the parser core and nfc_rfp_frame_checker

module tb_top;

    import nfc_rfp_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;     // margin for a result to pass the input and result registers
    localparam int BLOCK_BYTES   = 170;   // frame bytes per register setting
    localparam int LONG_HOLD     = 300;   // long receiver hold-off, in cycles

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [BYTE_W-1:0] cfg_wdata;

    nfc_rfp_in_if  frame_if ();
    nfc_rfp_out_if res_if ();

    int send_idle;          // percent of cycles the byte source holds back
    int recv_idle;          // percent of cycles the result sink holds back
    int rx_hold_left;       // long hold-off, counted down by the sink process
    int cycle_count;
    int frame_bytes_sent;
    int settings_used;

    // stimulus-side copy of the registers, used to build well-formed frames
    logic [BYTE_W-1:0] cur_cmd;
    logic [BYTE_W-1:0] cur_cap;
    logic [BYTE_W-1:0] fb[$];

    int mismatches;
    int pending;
    int payload_seen;
    int ok_frames;
    int invalid_frames;
    int no_space_frames;

    nfc_response_frame_parser_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .frame     (frame_if.sink),
        .res       (res_if.source)
    );

    nfc_rfp_frame_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .frame           (frame_if),
        .res             (res_if),
        .mismatches      (mismatches),
        .pending         (pending),
        .payload_seen    (payload_seen),
        .ok_frames       (ok_frames),
        .invalid_frames  (invalid_frames),
        .no_space_frames (no_space_frames)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result sink: random back-pressure, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            res_if.ready <= 1'b0;
            rx_hold_left--;
        end
        else
        begin
            res_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still awaited", CYCLE_LIMIT, pending);
        $display("** nfc_response_frame_parser_core: FAILED **");
        $finish;
    end

    // offer one byte, with random idle cycles first, and wait for the request to be taken
    task automatic drive_byte(input logic [BYTE_W-1:0] b, input logic s);
        while ($urandom_range(99) < send_idle)
        begin
            frame_if.valid <= 1'b0;
            @(posedge clk);
        end
        frame_if.valid <= 1'b1;
        frame_if.data  <= {b, s};
        @(posedge clk);
        while (!frame_if.ready) @(posedge clk);
        frame_bytes_sent++;
    endtask

    // the byte queue as one frame: frame_start on its first byte only
    task automatic send_fb();
        foreach (fb[i]) drive_byte(fb[i], i == 0);
    endtask

    // well-formed frame for the current command code with a random payload
    task automatic make_frame(input int plen);
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] b;
        code = cur_cmd + 8'd1;
        len  = BYTE_W'(plen + 2);
        sum  = DIR_TO_HOST + code;
        fb.delete();
        fb.push_back(PREAMBLE_BYTE);
        fb.push_back(PREAMBLE_BYTE);
        fb.push_back(START_BYTE);
        fb.push_back(len);
        fb.push_back(8'h00 - len);
        fb.push_back(DIR_TO_HOST);
        fb.push_back(code);
        repeat (plen)
        begin
            b   = BYTE_W'($urandom);
            sum = sum + b;
            fb.push_back(b);
        end
        fb.push_back(8'h00 - sum);
        fb.push_back(BYTE_W'($urandom));   // postamble, value not checked
    endtask

    // mostly well-formed frames, the rest broken at one field, cut short or plain noise
    task automatic send_random_frame();
        int                kind;
        int                plen;
        int                cut;
        logic [BYTE_W-1:0] nz;
        kind = $urandom_range(99);
        nz   = BYTE_W'($urandom_range(1, 255));
        plen = ($urandom_range(99) < 4) ? $urandom_range(13, 253) : $urandom_range(0, 10);
        if (kind >= 92)
        begin
            // stray bytes: unmarked ones are ignored while idle, fed into an open frame
            repeat ($urandom_range(1, 6))
                drive_byte(BYTE_W'($urandom), $urandom_range(7) == 0);
            return;
        end
        make_frame(plen);
        if (kind < 55) ;                           // good frame
        else if (kind < 60) fb[0] = nz;            // bad preamble
        else if (kind < 64) fb[1] = nz;            // bad second start byte
        else if (kind < 68) fb[2] = START_BYTE ^ nz;
        else if (kind < 72) fb[4] = fb[4] ^ nz;    // length checksum wrong
        else if (kind < 75)
        begin                                      // length too short, checksum good
            fb[3] = BYTE_W'($urandom_range(0, 1));
            fb[4] = 8'h00 - fb[3];
        end
        else if (kind < 79) fb[5] = fb[5] ^ nz;    // wrong direction byte
        else if (kind < 83) fb[6] = fb[6] ^ nz;    // wrong response code
        else if (kind < 87) fb[fb.size() - 2] = fb[fb.size() - 2] ^ nz;
        else
        begin
            // cut short: the next frame_start restarts mid-frame
            cut = $urandom_range(1, fb.size() - 1);
            fb  = fb[0:cut-1];
        end
        send_fb();
    endtask

    // source stops, every awaited result comes back, then the pipeline settles
    task automatic drain();
        frame_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers in back-to-back writes, parser idle
    task automatic load_settings(input logic [BYTE_W-1:0] cmd,
                                 input logic [BYTE_W-1:0] cap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_COMMAND;
        cfg_wdata <= cmd;
        @(posedge clk);
        cfg_index <= CFG_BUFFER_CAPACITY;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_cmd   = cmd;
        cur_cap   = cap;
        settings_used++;
    endtask

    initial
    begin
        int                blk;
        int                block_start;
        logic [BYTE_W-1:0] new_cmd;
        logic [BYTE_W-1:0] new_cap;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_EXPECTED_COMMAND;
        cfg_wdata        = '0;
        frame_if.valid   = 1'b0;
        frame_if.data    = '0;
        res_if.ready     = 1'b0;
        rx_hold_left     = 0;
        frame_bytes_sent = 0;
        settings_used    = 0;
        cur_cmd          = 8'h00;      // register values after reset
        cur_cap          = 8'hFF;
        send_idle        = 34;
        recv_idle        = 85;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values
        drive_byte(8'hFF, 1'b0);                   // byte while idle, no result
        drive_byte(8'h01, 1'b1);                   // bad preamble, invalid at once
        make_frame(0);                             // empty payload, ok
        send_fb();
        fb = '{8'h00, 8'h00, 8'hFF, 8'h01, 8'hFF}; // length below two
        send_fb();
        fb = '{8'h00, 8'h00};                      // abandoned, restarted by the next start
        send_fb();
        fb = '{8'h00, 8'h00, 8'hFF, 8'h03, 8'h00}; // bad length checksum
        send_fb();

        // random part: one block of frames per register setting
        for (blk = 0; blk < 6; blk++)
        begin
            drain();
            case (blk)
                0:
                begin
                    new_cmd = 8'h00;
                    new_cap = 8'hFF;
                end
                1:
                begin
                    new_cmd = 8'hFF;               // code wraps to zero
                    new_cap = 8'h00;
                end
                2:
                begin
                    new_cmd = BYTE_W'($urandom);
                    new_cap = BYTE_W'($urandom_range(1, 8));
                end
                3:
                begin
                    new_cmd = BYTE_W'($urandom);
                    new_cap = BYTE_W'($urandom_range(9, 255));
                end
                4:
                begin
                    new_cmd = BYTE_W'($urandom);
                    new_cap = 8'h04;
                end
                default:
                begin
                    new_cmd = 8'hFE;
                    new_cap = 8'hFF;
                end
            endcase
            if (blk < 2)
            begin
                send_idle = 34;
                recv_idle = 85;
            end
            else if (blk < 4)
            begin
                send_idle = 85;
                recv_idle = 34;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            load_settings(new_cmd, new_cap);

            // sink holds off while the source keeps pushing, so the core fills up
            if (blk == 4) rx_hold_left = LONG_HOLD;
            // largest payload, last index and longest length field
            if (blk == 5)
            begin
                make_frame(253);
                send_fb();
            end

            block_start = frame_bytes_sent;
            while (frame_bytes_sent - block_start < BLOCK_BYTES)
                send_random_frame();

            // a complete frame leaves the parser idle before the next register write
            make_frame($urandom_range(0, 4));
            send_fb();
        end

        drain();

        $display("covered %0d frame bytes under %0d register settings, three idling regimes",
                 frame_bytes_sent, settings_used);
        $display("results: %0d payload bytes, %0d ok, %0d invalid, %0d no-space frames",
                 payload_seen, ok_frames, invalid_frames, no_space_frames);
        if (mismatches == 0 && pending == 0)
        begin
            $display("** nfc_response_frame_parser_core: PASSED **");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches, pending);
            $display("** nfc_response_frame_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
